>>> hw/rtl/dhcp_reply_option_parser_assert.svh
// Assertion macros shared by the DHCP reply option parser modules.
`ifndef DHCP_REPLY_OPTION_PARSER_ASSERT_SVH
`define DHCP_REPLY_OPTION_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

`define DRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define DRP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DRP_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define DRP_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/dhcp_rop_pkg.sv
// Types, constants and helper functions of the DHCP reply option parser.
`timescale 1ns / 1ps
package dhcp_rop_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 1024;
    localparam int unsigned OFFSET_W         = 11;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX   = '1;
    localparam logic [OFFSET_W-1:0] OFFSET_LIMIT = OFFSET_W'(MAX_PACKET_BYTES);
    localparam logic [OFFSET_W-1:0] OFF_OP       = OFFSET_W'(0);
    localparam logic [OFFSET_W-1:0] OFF_YIADDR   = OFFSET_W'(16);
    localparam logic [OFFSET_W-1:0] OFF_YIADDR_E = OFFSET_W'(19);
    localparam logic [OFFSET_W-1:0] OFF_OPTIONS  = OFFSET_W'(240);

    localparam logic [7:0] TAG_PAD    = 8'd0;
    localparam logic [7:0] TAG_SUBNET = 8'd1;
    localparam logic [7:0] TAG_ROUTER = 8'd3;
    localparam logic [7:0] TAG_DNS    = 8'd6;
    localparam logic [7:0] TAG_TYPE   = 8'd53;
    localparam logic [7:0] TAG_SERVER = 8'd54;
    localparam logic [7:0] TAG_END    = 8'hff;

    localparam logic [7:0] OP_REPLY  = 8'h2;
    localparam logic [7:0] MSG_OFFER = 8'h2;
    localparam logic [7:0] MSG_ACK   = 8'h5;

    localparam int unsigned FOUND_W = 5;
    localparam int unsigned FB_TYPE   = 0;
    localparam int unsigned FB_SERVER = 1;
    localparam int unsigned FB_SUBNET = 2;
    localparam int unsigned FB_ROUTER = 3;
    localparam int unsigned FB_DNS    = 4;

    typedef enum logic [1:0] {
        ACT_IGNORE  = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_APPLY   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef struct packed {
        logic               ended_properly;
        logic [FOUND_W-1:0] found_mask;
        logic [31:0]        dns_address;
        logic [31:0]        router_address;
        logic [31:0]        netmask;
        logic [31:0]        server_address;
        logic [31:0]        offered_address;
        logic [7:0]         message_type;
        action_t            action;
    } rop_result_t;

    function automatic logic [FOUND_W-1:0] tag_bit(input logic [7:0] tag);
        logic [FOUND_W-1:0] bits;
        bits = '0;
        case (tag)
            TAG_TYPE:   bits[FB_TYPE]   = 1'b1;
            TAG_SERVER: bits[FB_SERVER] = 1'b1;
            TAG_SUBNET: bits[FB_SUBNET] = 1'b1;
            TAG_ROUTER: bits[FB_ROUTER] = 1'b1;
            TAG_DNS:    bits[FB_DNS]    = 1'b1;
            default:    bits = '0;
        endcase
        return bits;
    endfunction

    function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] idx,
                                             input logic [7:0] b);
        logic [31:0] w;
        w = word;
        case (idx)
            2'd0:    w[31:24] = b;
            2'd1:    w[23:16] = b;
            2'd2:    w[15:8]  = b;
            default: w[7:0]   = b;
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/dhcp_reply_option_parser.sv
// Top level of the DHCP reply option parser.
//
//  channel  | dir | handshake            | content
//  s_       | in  | s_tvalid / s_tready  | s_tdata packet_byte, s_tlast last_byte
//  m_       | out | m_tvalid / m_tready  | m_tdata result of one packet
//
// One byte is taken per cycle while s_tready is high; the per-byte parse is a single
// register-to-register step; a packet's result is registered in the output buffer.
// Output register plus skid stage: s_tready drops only while two results wait.
// Synchronous active-low reset clears parse state and the bound lease flag.
`timescale 1ns / 1ps
module dhcp_reply_option_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] packet_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [175:0] m_tdata    // [1:0] action, [9:2] message_type,
                                    // [41:10] offered_address, [73:42] server_address,
                                    // [105:74] netmask, [137:106] router_address,
                                    // [169:138] dns_address, [174:170] found_mask,
                                    // [175] ended_properly
);
    import dhcp_rop_pkg::*;

    logic        accept;
    logic        res_push;
    logic        buf_full;
    rop_result_t res_data;
    rop_result_t out_data;

    assign s_tready = !buf_full;
    assign accept   = s_tvalid && s_tready;

    dhcp_rop_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    dhcp_rop_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.ended_properly, out_data.found_mask, out_data.dns_address,
                      out_data.router_address, out_data.netmask, out_data.server_address,
                      out_data.offered_address, out_data.message_type, out_data.action};

endmodule

>>> hw/rtl/dhcp_rop_parse.sv
// Per-byte header and option parser with lease state; yields one result per packet.
`timescale 1ns / 1ps
`include "dhcp_reply_option_parser_assert.svh"
module dhcp_rop_parse (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_accept,
    input  logic [7:0]                in_byte,
    input  logic                      in_last,
    output logic                      res_push,
    output dhcp_rop_pkg::rop_result_t res_data
);
    import dhcp_rop_pkg::*;

    logic [OFFSET_W-1:0] offset_reg, offset_next;
    phase_t              phase_reg, phase_next;
    logic [7:0]          tag_reg, tag_next;
    logic [7:0]          left_reg, left_next;
    logic [2:0]          vidx_reg, vidx_next;
    logic [7:0]          op_reg, op_next;
    logic [31:0]         offer_reg, offer_next;
    logic [31:0]         server_reg, server_next;
    logic [31:0]         subnet_reg, subnet_next;
    logic [31:0]         router_reg, router_next;
    logic [31:0]         dns_reg, dns_next;
    logic [7:0]          type_reg, type_next;
    logic [FOUND_W-1:0]  seen_reg, seen_next;
    logic                end_reg, end_next;
    logic                bound_reg, bound_next;

    logic [FOUND_W-1:0]  bit_sel;
    logic [7:0]          msg_type;
    action_t             act;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            phase_reg  <= PH_TAG;
            tag_reg    <= '0;
            left_reg   <= '0;
            vidx_reg   <= '0;
            op_reg     <= '0;
            offer_reg  <= '0;
            server_reg <= '0;
            subnet_reg <= '0;
            router_reg <= '0;
            dns_reg    <= '0;
            type_reg   <= '0;
            seen_reg   <= '0;
            end_reg    <= 1'b0;
            bound_reg  <= 1'b0;
        end else begin
            offset_reg <= offset_next;
            phase_reg  <= phase_next;
            tag_reg    <= tag_next;
            left_reg   <= left_next;
            vidx_reg   <= vidx_next;
            op_reg     <= op_next;
            offer_reg  <= offer_next;
            server_reg <= server_next;
            subnet_reg <= subnet_next;
            router_reg <= router_next;
            dns_reg    <= dns_next;
            type_reg   <= type_next;
            seen_reg   <= seen_next;
            end_reg    <= end_next;
            bound_reg  <= bound_next;
        end
    end

    always_comb begin
        offset_next = offset_reg;
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        left_next   = left_reg;
        vidx_next   = vidx_reg;
        op_next     = op_reg;
        offer_next  = offer_reg;
        server_next = server_reg;
        subnet_next = subnet_reg;
        router_next = router_reg;
        dns_next    = dns_reg;
        type_next   = type_reg;
        seen_next   = seen_reg;
        end_next    = end_reg;
        bound_next  = bound_reg;
        bit_sel     = tag_bit(tag_reg);
        msg_type    = '0;
        act         = ACT_IGNORE;
        res_push    = 1'b0;

        if (in_accept) begin
            if (offset_reg < OFFSET_LIMIT) begin
                if (offset_reg == OFF_OP) begin
                    op_next = in_byte;
                end else if (offset_reg >= OFF_YIADDR && offset_reg <= OFF_YIADDR_E) begin
                    offer_next = put_byte(offer_reg, offset_reg[1:0], in_byte);
                end else if (offset_reg >= OFF_OPTIONS) begin
                    unique case (phase_reg)
                        PH_TAG: begin
                            if (in_byte == TAG_END) begin
                                end_next   = 1'b1;
                                phase_next = PH_DONE;
                            end else if (in_byte != TAG_PAD) begin
                                tag_next   = in_byte;
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            if (bit_sel != '0 && (seen_reg & bit_sel) == '0) begin
                                seen_next = seen_reg | bit_sel;
                            end else begin
                                tag_next = '0;
                            end
                            left_next  = in_byte;
                            vidx_next  = '0;
                            phase_next = (in_byte == 8'd0) ? PH_TAG : PH_VAL;
                        end
                        PH_VAL: begin
                            if (!vidx_reg[2]) begin
                                case (tag_reg)
                                    TAG_TYPE: begin
                                        if (vidx_reg == 3'd0) begin
                                            type_next = in_byte;
                                        end
                                    end
                                    TAG_SERVER: server_next = put_byte(server_reg, vidx_reg[1:0], in_byte);
                                    TAG_SUBNET: subnet_next = put_byte(subnet_reg, vidx_reg[1:0], in_byte);
                                    TAG_ROUTER: router_next = put_byte(router_reg, vidx_reg[1:0], in_byte);
                                    TAG_DNS:    dns_next    = put_byte(dns_reg, vidx_reg[1:0], in_byte);
                                    default: ;
                                endcase
                                vidx_next = vidx_reg + 3'd1;
                            end
                            left_next = left_reg - 8'd1;
                            if (left_reg == 8'd1) begin
                                phase_next = PH_TAG;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (offset_reg != OFFSET_MAX) begin
                offset_next = offset_reg + OFFSET_W'(1);
            end

            if (in_last) begin
                res_push = 1'b1;
                msg_type = seen_next[FB_TYPE] ? type_next : 8'd0;
                if (op_next == OP_REPLY) begin
                    if (msg_type == MSG_OFFER) begin
                        act = ACT_REQUEST;
                    end else if (msg_type == MSG_ACK && !bound_reg) begin
                        act        = ACT_APPLY;
                        bound_next = 1'b1;
                    end
                end
            end
        end

        res_data.action          = act;
        res_data.message_type    = msg_type;
        res_data.offered_address = offer_next;
        res_data.server_address  = server_next;
        res_data.netmask         = subnet_next;
        res_data.router_address  = router_next;
        res_data.dns_address     = dns_next;
        res_data.found_mask      = seen_next;
        res_data.ended_properly  = end_next;

        if (in_accept && in_last) begin
            offset_next = '0;
            phase_next  = PH_TAG;
            tag_next    = '0;
            left_next   = '0;
            vidx_next   = '0;
            op_next     = '0;
            offer_next  = '0;
            server_next = '0;
            subnet_next = '0;
            router_next = '0;
            dns_next    = '0;
            type_next   = '0;
            seen_next   = '0;
            end_next    = 1'b0;
        end
    end

    `DRP_ASSERT_IMP(a_done_has_end, aclk, aresetn, phase_reg == PH_DONE, end_reg)
    `DRP_ASSERT_IMP(a_vidx_range, aclk, aresetn, 1'b1, vidx_reg <= 3'd4)
    `DRP_ASSERT_NXT(a_apply_binds, aclk, aresetn, res_push && res_data.action == ACT_APPLY,
                    bound_reg)
    `DRP_ASSERT_IMP(a_apply_once, aclk, aresetn, bound_reg && res_push,
                    res_data.action != ACT_APPLY)
    `DRP_ASSERT_NXT(a_last_clears, aclk, aresetn, in_accept && in_last,
                    offset_reg == '0 && seen_reg == '0 && !end_reg)

endmodule

>>> hw/rtl/dhcp_rop_obuf.sv
// Two-entry result buffer: output register plus skid stage.
`timescale 1ns / 1ps
`include "dhcp_reply_option_parser_assert.svh"
module dhcp_rop_obuf (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  dhcp_rop_pkg::rop_result_t push_data,
    output logic                      full,
    output logic                      out_valid,
    input  logic                      out_ready,
    output dhcp_rop_pkg::rop_result_t out_data
);
    import dhcp_rop_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    rop_result_t out_data_reg, out_data_next;
    rop_result_t skid_data_reg, skid_data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (skid_valid_reg && out_ready) begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (push) begin
            if (!out_valid_next) begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `DRP_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `DRP_ASSERT_IMP(a_no_push_when_full, aclk, aresetn, skid_valid_reg, !push)
    `DRP_ASSERT_NXT(a_stall_fills_skid, aclk, aresetn,
                    push && out_valid_reg && !out_ready, skid_valid_reg)
    `DRP_ASSERT_NXT(a_skid_drains, aclk, aresetn, skid_valid_reg && out_ready && !push,
                    out_valid_reg && !skid_valid_reg)

endmodule

>>> tb/dhcp_reply_option_parser_tb.sv
// Self-checking testbench for the DHCP reply option parser: packet bytes in, one parsed reply out.
`timescale 1ns / 1ps
module dhcp_reply_option_parser_tb;
    import dhcp_rop_pkg::*;

    localparam int unsigned RESET_CYCLES    = 12;
    localparam int unsigned BYTE_TARGET     = 1350;
    localparam int unsigned PACKET_TARGET   = 48;
    localparam int unsigned CYCLE_LIMIT     = 1500000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES     = 20;
    localparam int unsigned HEADER_BYTES    = 236;
    localparam logic [31:0] COOKIE          = 32'h6382_5363;

    typedef struct packed {
        logic [7:0]   op;
        logic [31:0]  yiaddr;
        logic [5:0]   opt_len;
        logic [255:0] opts;
        logic [11:0]  pkt_len;
        logic [7:0]   filler;
        logic         typed;
        rop_result_t  want;
    } probe_row_t;

    localparam probe_row_t PROBE_ROWS [17] = '{
        '{op: OP_REPLY, yiaddr: 32'hc0a8_0a64, opt_len: 4, opts: 256'h35_01_02_ff,
          pkt_len: 0, filler: 0, typed: 1'b1,
          want: '{ended_properly: 1'b1, found_mask: 5'h01, dns_address: 32'h0,
                  router_address: 32'h0, netmask: 32'h0, server_address: 32'h0,
                  offered_address: 32'hc0a8_0a64, message_type: MSG_OFFER,
                  action: ACT_REQUEST}},
        '{op: 8'h01, yiaddr: 32'hc0a8_0a65, opt_len: 4, opts: 256'h35_01_02_ff,
          pkt_len: 0, filler: 0, typed: 1'b1,
          want: '{ended_properly: 1'b1, found_mask: 5'h01, dns_address: 32'h0,
                  router_address: 32'h0, netmask: 32'h0, server_address: 32'h0,
                  offered_address: 32'hc0a8_0a65, message_type: MSG_OFFER,
                  action: ACT_IGNORE}},
        '{op: OP_REPLY, yiaddr: 32'h0a00_0005, opt_len: 28,
          opts: 256'h350105_3604c0a80a01_0104ffffff00_0304c0a80afe_060408080404_ff,
          pkt_len: 0, filler: 0, typed: 1'b1,
          want: '{ended_properly: 1'b1, found_mask: 5'h1f, dns_address: 32'h0808_0404,
                  router_address: 32'hc0a8_0afe, netmask: 32'hffff_ff00,
                  server_address: 32'hc0a8_0a01, offered_address: 32'h0a00_0005,
                  message_type: MSG_ACK, action: ACT_APPLY}},
        '{op: OP_REPLY, yiaddr: 32'h0a00_0005, opt_len: 28,
          opts: 256'h350105_3604c0a80a01_0104ffffff00_0304c0a80afe_060408080404_ff,
          pkt_len: 0, filler: 0, typed: 1'b1,
          want: '{ended_properly: 1'b1, found_mask: 5'h1f, dns_address: 32'h0808_0404,
                  router_address: 32'hc0a8_0afe, netmask: 32'hffff_ff00,
                  server_address: 32'hc0a8_0a01, offered_address: 32'h0a00_0005,
                  message_type: MSG_ACK, action: ACT_IGNORE}},
        '{op: OP_REPLY, yiaddr: 32'h0a00_0010, opt_len: 13,
          opts: 256'h00_00_350102_350105_3602aabb_ff,
          pkt_len: 0, filler: 0, typed: 1'b0, want: '0},
        '{op: OP_REPLY, yiaddr: 32'h0a00_0011, opt_len: 8, opts: 256'h0100_0300_350102_ff,
          pkt_len: 0, filler: 0, typed: 1'b0, want: '0},
        '{op: OP_REPLY, yiaddr: 32'h0a00_0012, opt_len: 12,
          opts: 256'h0606112233445566_350107_ff,
          pkt_len: 0, filler: 0, typed: 1'b0, want: '0},
        '{op: OP_REPLY, yiaddr: 32'h0a00_0013, opt_len: 8, opts: 256'hfe03010203_3500_ff,
          pkt_len: 0, filler: 0, typed: 1'b0, want: '0},
        '{op: OP_REPLY, yiaddr: 32'h0a00_00aa, opt_len: 10, opts: 256'hff_350105_360401020304,
          pkt_len: 0, filler: 0, typed: 1'b1,
          want: '{ended_properly: 1'b1, found_mask: 5'h00, dns_address: 32'h0,
                  router_address: 32'h0, netmask: 32'h0, server_address: 32'h0,
                  offered_address: 32'h0a00_00aa, message_type: 8'h00,
                  action: ACT_IGNORE}},
        '{op: OP_REPLY, yiaddr: 32'h0a00_0014, opt_len: 0, opts: '0,
          pkt_len: 10, filler: 0, typed: 1'b1, want: '0},
        '{op: OP_REPLY, yiaddr: 32'h0a00_0015, opt_len: 7, opts: 256'h350102_36040102,
          pkt_len: 0, filler: 0, typed: 1'b0, want: '0},
        '{op: OP_REPLY, yiaddr: 32'h0a00_0016, opt_len: 3, opts: 256'h350102,
          pkt_len: 0, filler: 0, typed: 1'b0, want: '0},
        '{op: 8'hff, yiaddr: 32'hffff_ffff, opt_len: 10, opts: 256'h3501ff_3604ffffffff_ff,
          pkt_len: 0, filler: 0, typed: 1'b1,
          want: '{ended_properly: 1'b1, found_mask: 5'h03, dns_address: 32'h0,
                  router_address: 32'h0, netmask: 32'h0, server_address: 32'hffff_ffff,
                  offered_address: 32'hffff_ffff, message_type: 8'hff,
                  action: ACT_IGNORE}},
        '{op: OP_REPLY, yiaddr: 32'h0a00_0017, opt_len: 0, opts: '0,
          pkt_len: 1, filler: 0, typed: 1'b1, want: '0},
        '{op: OP_REPLY, yiaddr: 32'h0a00_0018, opt_len: 3, opts: 256'h350102,
          pkt_len: 1100, filler: 0, typed: 1'b0, want: '0},
        '{op: OP_REPLY, yiaddr: 32'h0a00_0019, opt_len: 3, opts: 256'h350105,
          pkt_len: 2100, filler: 0, typed: 1'b0, want: '0},
        '{op: 8'h01, yiaddr: 32'h0a00_001a, opt_len: 3, opts: 256'h350105,
          pkt_len: 250, filler: 0, typed: 1'b0, want: '0}
    };

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [175:0] m_tdata;

    logic [OFFSET_W-1:0] pr_offset;
    phase_t              pr_phase;
    logic [7:0]          pr_tag;
    logic [7:0]          pr_left;
    logic [2:0]          pr_vidx;
    logic [7:0]          pr_op;
    logic [7:0]          pr_type;
    logic [31:0]         pr_offer;
    logic [31:0]         pr_server;
    logic [31:0]         pr_subnet;
    logic [31:0]         pr_router;
    logic [31:0]         pr_dns;
    logic [FOUND_W-1:0]  pr_seen;
    logic                pr_end;
    logic                pr_bound;

    rop_result_t reply_q [$];
    logic [7:0]  pkt_bytes [$];
    rop_result_t typed_reply;
    rop_result_t mon_reply;
    logic        mon_produced;
    bit          typed_armed;
    bit          steady;
    bit          hold_off_req;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned bytes_sent;
    int unsigned packets_sent;
    int unsigned replies_checked;
    int unsigned requests_seen;
    int unsigned applies_seen;
    int unsigned overlong_count;

    dhcp_reply_option_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    task automatic clear_parse();
        pr_offset = '0;
        pr_phase  = PH_TAG;
        pr_tag    = '0;
        pr_left   = '0;
        pr_vidx   = '0;
        pr_op     = '0;
        pr_type   = '0;
        pr_offer  = '0;
        pr_server = '0;
        pr_subnet = '0;
        pr_router = '0;
        pr_dns    = '0;
        pr_seen   = '0;
        pr_end    = 1'b0;
    endtask

    task automatic parse_reply_byte(input logic [7:0] b, input logic last,
                                    output logic produced, output rop_result_t reply);
        logic [FOUND_W-1:0] sel;
        logic [7:0]         type_seen;
        int                 vi;
        produced = 1'b0;
        reply    = '0;
        if (pr_offset < OFFSET_LIMIT) begin
            if (pr_offset == OFF_OP) begin
                pr_op = b;
            end else if (pr_offset >= OFF_YIADDR && pr_offset <= OFF_YIADDR_E) begin
                vi = int'(pr_offset - OFF_YIADDR);
                pr_offer[31 - 8 * vi -: 8] = b;
            end else if (pr_offset >= OFF_OPTIONS) begin
                case (pr_phase)
                    PH_TAG: begin
                        if (b == TAG_END) begin
                            pr_end   = 1'b1;
                            pr_phase = PH_DONE;
                        end else if (b != TAG_PAD) begin
                            pr_tag   = b;
                            pr_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        sel = '0;
                        case (pr_tag)
                            TAG_TYPE:   sel[FB_TYPE]   = 1'b1;
                            TAG_SERVER: sel[FB_SERVER] = 1'b1;
                            TAG_SUBNET: sel[FB_SUBNET] = 1'b1;
                            TAG_ROUTER: sel[FB_ROUTER] = 1'b1;
                            TAG_DNS:    sel[FB_DNS]    = 1'b1;
                            default:    sel = '0;
                        endcase
                        // later instances of a tracked tag are skipped, not captured
                        if (sel != '0 && (pr_seen & sel) == '0) pr_seen = pr_seen | sel;
                        else pr_tag = TAG_PAD;
                        pr_left  = b;
                        pr_vidx  = '0;
                        pr_phase = (b == 8'd0) ? PH_TAG : PH_VAL;
                    end
                    PH_VAL: begin
                        if (pr_vidx < 3'd4) begin
                            vi = int'(pr_vidx);
                            case (pr_tag)
                                TAG_TYPE:   if (vi == 0) pr_type = b;
                                TAG_SERVER: pr_server[31 - 8 * vi -: 8] = b;
                                TAG_SUBNET: pr_subnet[31 - 8 * vi -: 8] = b;
                                TAG_ROUTER: pr_router[31 - 8 * vi -: 8] = b;
                                TAG_DNS:    pr_dns[31 - 8 * vi -: 8]    = b;
                                default: ;
                            endcase
                            pr_vidx = pr_vidx + 3'd1;
                        end
                        pr_left = pr_left - 8'd1;
                        if (pr_left == 8'd0) pr_phase = PH_TAG;
                    end
                    default: ;
                endcase
            end
        end
        if (pr_offset != OFFSET_MAX) pr_offset = pr_offset + 1'b1;
        if (last) begin
            type_seen    = pr_seen[FB_TYPE] ? pr_type : 8'h00;
            reply.action = ACT_IGNORE;
            if (pr_op == OP_REPLY) begin
                if (type_seen == MSG_OFFER) begin
                    reply.action = ACT_REQUEST;
                end else if (type_seen == MSG_ACK && !pr_bound) begin
                    reply.action = ACT_APPLY;
                    pr_bound     = 1'b1;
                end
            end
            reply.message_type    = type_seen;
            reply.offered_address = pr_offer;
            reply.server_address  = pr_server;
            reply.netmask         = pr_subnet;
            reply.router_address  = pr_router;
            reply.dns_address     = pr_dns;
            reply.found_mask      = pr_seen;
            reply.ended_properly  = pr_end;
            produced              = 1'b1;
            clear_parse();
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void compare_reply(input rop_result_t want, input rop_result_t got);
        check_field("action", 32'(want.action), 32'(got.action));
        check_field("message_type", 32'(want.message_type), 32'(got.message_type));
        check_field("offered_address", want.offered_address, got.offered_address);
        check_field("server_address", want.server_address, got.server_address);
        check_field("netmask", want.netmask, got.netmask);
        check_field("router_address", want.router_address, got.router_address);
        check_field("dns_address", want.dns_address, got.dns_address);
        check_field("found_mask", 32'(want.found_mask), 32'(got.found_mask));
        check_field("ended_properly", 32'(want.ended_properly), 32'(got.ended_properly));
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                parse_reply_byte(s_tdata, s_tlast, mon_produced, mon_reply);
                if (mon_produced) begin
                    if (typed_armed) begin
                        reply_q.push_back(typed_reply);
                        typed_armed = 1'b0;
                    end else begin
                        reply_q.push_back(mon_reply);
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    $error("reply with no packet outstanding: %0h", m_tdata);
                    mismatch_count++;
                end else begin
                    compare_reply(reply_q.pop_front(), rop_result_t'(m_tdata));
                end
                replies_checked++;
                if (m_tdata[1:0] == ACT_REQUEST) requests_seen++;
                if (m_tdata[1:0] == ACT_APPLY) applies_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count,
                     reply_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    initial begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall        = HOLD_OFF_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                stall = idle_len();
                m_tready <= (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_bytes.size(); i++) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        packets_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(negedge aclk);
    endtask

    task automatic push_header(input logic [7:0] op, input logic [31:0] yi, input bit real_cookie);
        pkt_bytes.delete();
        for (int i = 0; i < HEADER_BYTES; i++) begin
            if (i == OFF_OP) pkt_bytes.push_back(op);
            else if (i >= OFF_YIADDR && i <= OFF_YIADDR_E) pkt_bytes.push_back(yi[31 - 8 * (i - 16) -: 8]);
            else pkt_bytes.push_back(8'($urandom));
        end
        for (int i = 0; i < 4; i++) pkt_bytes.push_back(real_cookie ? COOKIE[31 - 8 * i -: 8] : 8'($urandom));
    endtask

    task automatic push_option(input logic [7:0] tag, input int len);
        logic [7:0] v;
        pkt_bytes.push_back(tag);
        pkt_bytes.push_back(8'(len));
        for (int i = 0; i < len; i++) begin
            v = 8'($urandom);
            if (tag == TAG_TYPE && i == 0) begin
                case ($urandom_range(0, 3))
                    0:       v = MSG_OFFER;
                    1:       v = MSG_ACK;
                    2:       v = 8'h00;
                    default: v = 8'($urandom);
                endcase
            end
            pkt_bytes.push_back(v);
        end
    endtask

    task automatic build_short(input int max_len);
        pkt_bytes.delete();
        repeat ($urandom_range(1, max_len)) pkt_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1)) pkt_bytes[0] = OP_REPLY;
    endtask

    task automatic build_probe(input probe_row_t row);
        int n;
        int total;
        n = row.opt_len;
        push_header(row.op, row.yiaddr, 1'b1);
        for (int i = 0; i < n; i++) pkt_bytes.push_back(row.opts[8 * (n - 1 - i) +: 8]);
        total = (row.pkt_len == 0) ? pkt_bytes.size() : row.pkt_len;
        while (pkt_bytes.size() > total) void'(pkt_bytes.pop_back());
        // pad out with filler and close with an end tag on the final byte
        while (pkt_bytes.size() < total) pkt_bytes.push_back((pkt_bytes.size() == total - 1) ? TAG_END : row.filler);
    endtask

    task automatic build_random_reply();
        int         r;
        int         total;
        logic [7:0] tag;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            build_short(40);
            return;
        end
        push_header(($urandom_range(0, 9) < 8) ? OP_REPLY : 8'($urandom), $urandom,
                    $urandom_range(0, 9) != 0);
        repeat ($urandom_range(0, 8)) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                pkt_bytes.push_back(TAG_PAD);
            end else if (r < 35) begin
                push_option(TAG_TYPE, ($urandom_range(0, 9) != 0) ? 1 : $urandom_range(0, 6));
            end else if (r < 75) begin
                case ($urandom_range(0, 3))
                    0:       tag = TAG_SERVER;
                    1:       tag = TAG_SUBNET;
                    2:       tag = TAG_ROUTER;
                    default: tag = TAG_DNS;
                endcase
                push_option(tag, ($urandom_range(0, 4) != 0) ? 4 : $urandom_range(0, 8));
            end else begin
                push_option(8'($urandom_range(1, 254)),
                            ($urandom_range(0, 19) != 0) ? $urandom_range(0, 10) : $urandom_range(0, 255));
            end
        end
        if (overlong_count < 2 && $urandom_range(0, 49) == 0) begin
            overlong_count++;
            total = $urandom_range(1030, 2100);
            while (pkt_bytes.size() < total) pkt_bytes.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 99) < 85) pkt_bytes.push_back(TAG_END);
        if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 5)) pkt_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            total = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > total) void'(pkt_bytes.pop_back());
        end
    endtask

    initial begin
        int random_packets;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        s_tlast        = 1'b0;
        steady         = 1'b0;
        hold_off_req   = 1'b0;
        typed_armed    = 1'b0;
        random_packets = 0;
        clear_parse();
        pr_bound = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int n = 0; n < $size(PROBE_ROWS); n++) begin
            build_probe(PROBE_ROWS[n]);
            typed_reply = PROBE_ROWS[n].want;
            typed_armed = PROBE_ROWS[n].typed;
            send_packet();
        end
        wait_drained();

        // hold the result side off while short packets keep arriving
        hold_off_req = 1'b1;
        steady       = 1'b1;
        repeat (10) begin
            build_short(4);
            send_packet();
        end
        steady = 1'b0;
        wait_drained();

        while (bytes_sent < BYTE_TARGET || random_packets < PACKET_TARGET) begin
            steady = (random_packets % 6 == 5);
            build_random_reply();
            send_packet();
            random_packets++;
        end
        steady = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Covered %0d packets, %0d bytes: directed option cases, truncation, overlong",
                 packets_sent, bytes_sent);
        $display("and a long output hold-off; %0d replies, %0d requests, %0d lease applied",
                 replies_checked, requests_seen, applies_seen);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
